/* rtl/core/bcdt_pkg.sv */
// shared types and constants of the bounded city block distance transform
package bcdt_pkg;

    localparam int PIX_W  = 15;
    localparam int DIST_W = 16;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_MAX_DISTANCE    = 3'd0;
    localparam logic [2:0] REG_LINE_WIDTH      = 3'd1;
    localparam logic [2:0] REG_EDGE_FROM_VALUE = 3'd2;
    localparam logic [2:0] REG_MARK_EDGES_ONE  = 3'd3;
    localparam logic [2:0] REG_MARK_GROWN_ONE  = 3'd4;

    typedef struct packed {
        logic [4:0]  max_distance;
        logic [10:0] line_width;
        logic        edge_from_value;
        logic        mark_edges_one;
        logic        mark_grown_one;
    } cfg_t;

endpackage

/* rtl/core/bcdt_ram.sv */
// simple dual port ram with registered read
module bcdt_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bcdt_regs.sv */
// apb configuration registers
module bcdt_regs import bcdt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (paddr[4:2])
                REG_MAX_DISTANCE:    cfg_next.max_distance = pwdata[4:0];
                REG_LINE_WIDTH:      cfg_next.line_width = pwdata[10:0];
                REG_EDGE_FROM_VALUE: cfg_next.edge_from_value = pwdata[0];
                REG_MARK_EDGES_ONE:  cfg_next.mark_edges_one = pwdata[0];
                REG_MARK_GROWN_ONE:  cfg_next.mark_grown_one = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_distance <= 5'd8;
            cfg_reg.line_width <= 11'd1024;
            cfg_reg.edge_from_value <= 1'b0;
            cfg_reg.mark_edges_one <= 1'b0;
            cfg_reg.mark_grown_one <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MAX_DISTANCE:    prdata = {27'd0, cfg_reg.max_distance};
            REG_LINE_WIDTH:      prdata = {21'd0, cfg_reg.line_width};
            REG_EDGE_FROM_VALUE: prdata = {31'd0, cfg_reg.edge_from_value};
            REG_MARK_EDGES_ONE:  prdata = {31'd0, cfg_reg.mark_edges_one};
            REG_MARK_GROWN_ONE:  prdata = {31'd0, cfg_reg.mark_grown_one};
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/bounded_city_block_distance_transform.sv */
// top level: ring memories, flood fill stack and sequencer
// an accepted item reads both rings in S_RD; its result, if any, is registered in S_OUT once the
//   output is free, and an image item then updates the rings in S_EXEC, a read-modify-write
//   sequence on the single read port of the distance ring; no new item is taken before S_IDLE
// an edge item also flood fills, each popped entry passing S_FLAT and then S_FCHK and
//   S_FCMP for up to three neighbours; the first image item after reset or a flush sweeps
//   both rings in S_CLR; reset is synchronous active low and clears all control state
module bounded_city_block_distance_transform import bcdt_pkg::*; #(
    parameter int MAX_DIST  = 31,
    parameter int MAX_WIDTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [PIX_W-1:0]  s_pixel_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_pixel_out,
    output logic              m_end_of_line
);

    localparam int SLW       = $clog2(MAX_DIST + 1);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int ADW       = SLW + CW;
    localparam int RDEPTH    = 2 ** ADW;
    localparam int STACK_CAP = (MAX_DIST + 1) * MAX_WIDTH;
    localparam int SAW       = $clog2(STACK_CAP);
    localparam int SPW       = $clog2(STACK_CAP + 1);
    localparam int STW       = SLW + CW + DIST_W;
    localparam int RST_DMAX  = (MAX_DIST < 8) ? MAX_DIST : 8;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CLR  = 9'b000000010,
        S_RD   = 9'b000000100,
        S_OUT  = 9'b000001000,
        S_EXEC = 9'b000010000,
        S_FPOP = 9'b000100000,
        S_FLAT = 9'b001000000,
        S_FCHK = 9'b010000000,
        S_FCMP = 9'b100000000
    } state_t;

    cfg_t cfg;

    bcdt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // memory ports
    logic              pix_we, pix_re, dist_we, dist_re, stk_we, stk_re;
    logic [ADW-1:0]    pix_waddr, pix_raddr, dist_waddr, dist_raddr;
    logic [PIX_W-1:0]  pix_wdata, pix_rdata;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [STW-1:0]    stk_wdata, stk_rdata;

    bcdt_ram #(.DATA_W(PIX_W), .ADDR_W(ADW), .DEPTH(RDEPTH)) u_pix_ram (
        .aclk (aclk), .we (pix_we), .waddr (pix_waddr), .wdata (pix_wdata),
        .re (pix_re), .raddr (pix_raddr), .rdata (pix_rdata)
    );

    bcdt_ram #(.DATA_W(DIST_W), .ADDR_W(ADW), .DEPTH(RDEPTH)) u_dist_ram (
        .aclk (aclk), .we (dist_we), .waddr (dist_waddr), .wdata (dist_wdata),
        .re (dist_re), .raddr (dist_raddr), .rdata (dist_rdata)
    );

    bcdt_ram #(.DATA_W(STW), .ADDR_W(SAW), .DEPTH(STACK_CAP)) u_stack_ram (
        .aclk (aclk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
        .re (stk_re), .raddr (stk_raddr), .rdata (stk_rdata)
    );

    // control registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     colcnt_reg, colcnt_next;
    logic [SLW-1:0]    slot_reg, slot_next;
    logic [5:0]        lines_reg, lines_next;
    logic [DIST_W-1:0] left_reg, left_next;
    logic              start_reg, start_next;
    logic              m_valid_reg, m_valid_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [ADW-1:0]    clr_reg, clr_next;

    // payload registers
    logic              mode_reg, mode_next;
    logic [PIX_W-1:0]  v_reg, v_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [SLW-1:0]    cur_reg, cur_next;
    logic [SLW-1:0]    prev_reg, prev_next;
    logic              emit_reg, emit_next;
    logic              eol_reg, eol_next;
    logic [SLW-1:0]    dmax_reg, dmax_next;
    logic [DIST_W-1:0] dp1_reg, dp1_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [DIST_W-1:0] seed_reg, seed_next;
    logic              f2_reg, f2_next;
    logic              second_reg, second_next;
    logic              full_reg, full_next;
    logic [SLW-1:0]    tp_reg, tp_next;
    logic [CW-1:0]     ti_reg, ti_next;
    logic [DIST_W-1:0] tv_reg, tv_next;
    logic [1:0]        nb_reg, nb_next;
    logic [PIX_W-1:0]  m_pix_reg, m_pix_next;
    logic              m_eol_reg, m_eol_next;

    // effective register values
    logic [15:0]    md16, lw16;
    logic [SLW-1:0] dmax_c;
    logic [WW-1:0]  w_c;

    always_comb begin
        md16 = {11'd0, cfg.max_distance};
        if (md16 == 16'd0) begin
            md16 = 16'd1;
        end else if (md16 > 16'(MAX_DIST)) begin
            md16 = 16'(MAX_DIST);
        end
        lw16 = {5'd0, cfg.line_width};
        if (lw16 == 16'd0) begin
            lw16 = 16'd1;
        end else if (lw16 > 16'(MAX_WIDTH)) begin
            lw16 = 16'(MAX_WIDTH);
        end
        dmax_c = md16[SLW-1:0];
        w_c = lw16[WW-1:0];
    end

    // position of an accepted item
    logic              clr_c;
    logic [CW-1:0]     cc0, cc1;
    logic [SLW-1:0]    cs0, cs1, cs2;
    logic [5:0]        ls0, ls1;
    logic [DIST_W-1:0] ld0, ld1, dp1_c;

    always_comb begin
        clr_c = !s_mode && start_reg;
        dp1_c = 16'(dmax_c) + 16'd1;
        cc0 = clr_c ? '0 : colcnt_reg;
        cs0 = clr_c ? dmax_c : slot_reg;
        ls0 = clr_c ? 6'd0 : lines_reg;
        ld0 = clr_c ? dp1_c : left_reg;
        cc1 = (16'(cc0) >= 16'(w_c)) ? '0 : cc0;
        cs1 = (16'(cs0) > 16'(dmax_c)) ? '0 : cs0;
        cs2 = cs1;
        ls1 = ls0;
        ld1 = ld0;
        if (cc1 == '0) begin
            cs2 = (cs1 >= dmax_c) ? '0 : cs1 + SLW'(1);
            ld1 = dp1_c;
            if (ls0 < 6'd63) begin
                ls1 = ls0 + 6'd1;
            end
        end
    end

    // flood fill neighbor
    logic [SLW-1:0]    nb_slot, up_slot;
    logic [CW-1:0]     nb_col;
    logic              nb_ok;
    logic [DIST_W:0]   nv17;

    always_comb begin
        up_slot = (tp_reg == '0) ? dmax_reg : tp_reg - SLW'(1);
        nv17 = {1'b0, tv_reg} + 17'd1;
        nb_slot = tp_reg;
        nb_col = ti_reg;
        nb_ok = 1'b0;
        case (nb_reg)
            2'd0: begin
                nb_col = ti_reg + CW'(1);
                nb_ok = full_reg && (16'(ti_reg) + 16'd1 < 16'(w_reg));
            end
            2'd1: begin
                nb_col = ti_reg - CW'(1);
                nb_ok = ti_reg != '0;
            end
            2'd2: begin
                nb_slot = up_slot;
                nb_ok = full_reg && (up_slot != cur_reg);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // execute step values
    logic [DIST_W-1:0] dmin, nd_bg, nd_edge;
    logic [DIST_W:0]   m17, seed17;
    logic              f1_c, f2_c;
    logic [PIX_W-1:0]  p_out;

    always_comb begin
        dmin = (left_reg < dist_rdata) ? left_reg : dist_rdata;
        m17 = {1'b0, dmin} + 17'd1;
        nd_bg = (m17 < {1'b0, dp1_reg}) ? m17[DIST_W-1:0] : dp1_reg;
        nd_edge = cfg.edge_from_value ? {1'b0, v_reg} : '0;
        seed17 = {1'b0, nd_edge} + 17'd1;
        f1_c = {1'b0, dist_rdata} > seed17;
        f2_c = ({1'b0, left_reg} > seed17) && (col_reg != '0);
        p_out = pix_rdata;
        if (pix_rdata == '0) begin
            if (dist_rdata < dp1_reg) begin
                p_out = cfg.mark_grown_one ? PIX_W'(1) : dist_rdata[PIX_W-1:0];
            end
        end else if (cfg.mark_edges_one) begin
            p_out = PIX_W'(1);
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        colcnt_next = colcnt_reg;
        slot_next = slot_reg;
        lines_next = lines_reg;
        left_next = left_reg;
        start_next = start_reg;
        m_valid_next = m_valid_reg;
        sp_next = sp_reg;
        clr_next = clr_reg;
        mode_next = mode_reg;
        v_next = v_reg;
        col_next = col_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        emit_next = emit_reg;
        eol_next = eol_reg;
        dmax_next = dmax_reg;
        dp1_next = dp1_reg;
        w_next = w_reg;
        seed_next = seed_reg;
        f2_next = f2_reg;
        second_next = second_reg;
        full_next = full_reg;
        tp_next = tp_reg;
        ti_next = ti_reg;
        tv_next = tv_reg;
        nb_next = nb_reg;
        m_pix_next = m_pix_reg;
        m_eol_next = m_eol_reg;

        pix_we = 1'b0;
        pix_waddr = {cur_reg, col_reg};
        pix_wdata = v_reg;
        pix_re = 1'b0;
        pix_raddr = {cur_reg, col_reg};
        dist_we = 1'b0;
        dist_waddr = {cur_reg, col_reg};
        dist_wdata = nd_bg;
        dist_re = 1'b0;
        dist_raddr = {cur_reg, col_reg};
        stk_we = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = {nb_slot, nb_col, nv17[DIST_W-1:0]};
        stk_re = 1'b0;
        stk_raddr = SAW'(sp_reg - SPW'(1));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    v_next = s_pixel_value;
                    col_next = cc1;
                    cur_next = cs2;
                    prev_next = (cs2 == '0) ? dmax_c : cs2 - SLW'(1);
                    emit_next = {10'd0, ls1} > dp1_c;
                    eol_next = (16'(cc1) + 16'd1) == 16'(w_c);
                    dmax_next = dmax_c;
                    dp1_next = dp1_c;
                    w_next = w_c;
                    slot_next = cs2;
                    lines_next = ls1;
                    left_next = ld1;
                    colcnt_next = ((16'(cc1) + 16'd1) >= 16'(w_c)) ? '0 : cc1 + CW'(1);
                    start_next = s_mode;
                    clr_next = '0;
                    state_next = clr_c ? S_CLR : S_RD;
                end
            end
            S_CLR: begin
                pix_we = 1'b1;
                pix_waddr = clr_reg;
                pix_wdata = '0;
                dist_we = 1'b1;
                dist_waddr = clr_reg;
                dist_wdata = dp1_reg;
                clr_next = clr_reg + ADW'(1);
                if (clr_reg == {ADW{1'b1}}) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                pix_re = 1'b1;
                dist_re = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    if (emit_reg) begin
                        m_valid_next = 1'b1;
                        m_pix_next = p_out;
                        m_eol_next = eol_reg;
                    end
                    dist_re = 1'b1;
                    dist_raddr = {prev_reg, col_reg};
                    state_next = mode_reg ? S_IDLE : S_EXEC;
                end
            end
            S_EXEC: begin
                pix_we = 1'b1;
                dist_we = 1'b1;
                if (v_reg == '0) begin
                    left_next = nd_bg;
                    state_next = S_IDLE;
                end else begin
                    dist_wdata = nd_edge;
                    left_next = nd_edge;
                    seed_next = seed17[DIST_W-1:0];
                    f2_next = f2_c;
                    if (f1_c) begin
                        stk_we = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {prev_reg, col_reg, seed17[DIST_W-1:0]};
                        sp_next = SPW'(1);
                        full_next = 1'b1;
                        second_next = 1'b0;
                        state_next = S_FPOP;
                    end else if (f2_c) begin
                        stk_we = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {cur_reg, col_reg - CW'(1), seed17[DIST_W-1:0]};
                        sp_next = SPW'(1);
                        full_next = 1'b0;
                        second_next = 1'b1;
                        state_next = S_FPOP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FPOP: begin
                if (sp_reg == '0) begin
                    if (!second_reg && f2_reg) begin
                        stk_we = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {cur_reg, col_reg - CW'(1), seed_reg};
                        sp_next = SPW'(1);
                        full_next = 1'b0;
                        second_next = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    stk_re = 1'b1;
                    sp_next = sp_reg - SPW'(1);
                    state_next = S_FLAT;
                end
            end
            S_FLAT: begin
                tp_next = stk_rdata[STW-1 -: SLW];
                ti_next = stk_rdata[DIST_W +: CW];
                tv_next = stk_rdata[DIST_W-1:0];
                dist_we = 1'b1;
                dist_waddr = {stk_rdata[STW-1 -: SLW], stk_rdata[DIST_W +: CW]};
                dist_wdata = stk_rdata[DIST_W-1:0];
                nb_next = 2'd0;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (nb_ok) begin
                    dist_re = 1'b1;
                    dist_raddr = {nb_slot, nb_col};
                    state_next = S_FCMP;
                end else if (nb_reg == 2'd2) begin
                    state_next = S_FPOP;
                end else begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            S_FCMP: begin
                if (({1'b0, dist_rdata} > nv17) && (sp_reg < SPW'(STACK_CAP))) begin
                    stk_we = 1'b1;
                    sp_next = sp_reg + SPW'(1);
                end
                if (nb_reg == 2'd2) begin
                    state_next = S_FPOP;
                end else begin
                    nb_next = nb_reg + 2'd1;
                    state_next = S_FCHK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            colcnt_reg <= '0;
            slot_reg <= SLW'(RST_DMAX);
            lines_reg <= '0;
            left_reg <= DIST_W'(RST_DMAX + 1);
            start_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            sp_reg <= '0;
            clr_reg <= '0;
        end else begin
            state_reg <= state_next;
            colcnt_reg <= colcnt_next;
            slot_reg <= slot_next;
            lines_reg <= lines_next;
            left_reg <= left_next;
            start_reg <= start_next;
            m_valid_reg <= m_valid_next;
            sp_reg <= sp_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        v_reg <= v_next;
        col_reg <= col_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        emit_reg <= emit_next;
        eol_reg <= eol_next;
        dmax_reg <= dmax_next;
        dp1_reg <= dp1_next;
        w_reg <= w_next;
        seed_reg <= seed_next;
        f2_reg <= f2_next;
        second_reg <= second_next;
        full_reg <= full_next;
        tp_reg <= tp_next;
        ti_reg <= ti_next;
        tv_reg <= tv_next;
        nb_reg <= nb_next;
        m_pix_reg <= m_pix_next;
        m_eol_reg <= m_eol_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_pixel_out = m_pix_reg;
    assign m_end_of_line = m_eol_reg;

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_CAP))
        else $error("flood stack pointer past capacity");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(dist_we || pix_we || stk_we))
        else $error("ring or stack written while idle");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_re |-> (sp_reg != '0))
        else $error("pop from empty flood stack");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_pix_reg)))
        else $error("result lost while stalled");

endmodule

/* tb/bounded_city_block_distance_transform_tb.sv */
// self-checking testbench of the bounded city block distance transform
module bounded_city_block_distance_transform_tb import bcdt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_ROWS  = 32;
    localparam int RING_COLS  = 1024;
    localparam int RING_CELLS = RING_ROWS * RING_COLS;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 5000;

    typedef struct {
        logic             mode;
        logic [PIX_W-1:0] pixel;
    } pix_item_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             eol;
    } out_pix_t;

    typedef struct {
        int slot;
        int col;
        int val;
    } fill_entry_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_mode = 1'b0;
    logic [PIX_W-1:0]  s_pixel_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PIX_W-1:0]  m_pixel_out;
    logic              m_end_of_line;

    bounded_city_block_distance_transform DUT (.*);

    pix_item_t   pending_pixels[$];
    out_pix_t    expected_pixels[$];
    fill_entry_t fill_stack[$];
    int          errors = 0;
    int          idle_mode = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;

    // predictor state
    bit [15:0] pix_ring[RING_CELLS];
    bit [15:0] dist_ring[RING_CELLS];
    int  cfg_max_dist = 8;
    int  cfg_width = 1024;
    bit  cfg_edge_val = 0;
    bit  cfg_edges_one = 0;
    bit  cfg_grown_one = 0;
    int  slot_now, col_now, lines_cnt, left_dist;
    bit  restart_pending = 1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int cidx(int slot, int col);
        return (slot % RING_ROWS) * RING_COLS + (col % RING_COLS);
    endfunction

    function automatic int eff_dmax();
        return (cfg_max_dist < 1) ? 1 : (cfg_max_dist > 31 ? 31 : cfg_max_dist);
    endfunction

    function automatic int eff_width();
        return (cfg_width < 1) ? 1 : (cfg_width > RING_COLS ? RING_COLS : cfg_width);
    endfunction

    function automatic void push_fill(int slot, int col, int val);
        if (fill_stack.size() < RING_CELLS)
            fill_stack.push_back('{slot, col, val});
    endfunction

    function automatic void flood_fill(int slot, int col, int seed, bit full, int cur,
                                       int dmax, int w);
        fill_entry_t e;
        int nv, up;
        fill_stack.delete();
        push_fill(slot, col, seed);
        while (fill_stack.size() > 0) begin
            e = fill_stack.pop_back();
            nv = e.val + 1;
            dist_ring[cidx(e.slot, e.col)] = e.val[15:0];
            if (full && e.col + 1 < w && dist_ring[cidx(e.slot, e.col + 1)] > nv)
                push_fill(e.slot, e.col + 1, nv);
            if (e.col > 0 && dist_ring[cidx(e.slot, e.col - 1)] > nv)
                push_fill(e.slot, e.col - 1, nv);
            if (full) begin
                up = (e.slot == 0) ? dmax : e.slot - 1;
                if (up != cur && dist_ring[cidx(up, e.col)] > nv)
                    push_fill(up, e.col, nv);
            end
        end
    endfunction

    function automatic void predict_pixel(pix_item_t it);
        int dmax, dp1, w, cur, prev, idx, p, d, nd, m;
        out_pix_t o;
        dmax = eff_dmax();
        dp1 = dmax + 1;
        w = eff_width();
        if (!it.mode && restart_pending) begin
            for (int k = 0; k < RING_CELLS; k++) begin
                pix_ring[k] = '0;
                dist_ring[k] = 16'(dp1);
            end
            slot_now = dmax;
            col_now = 0;
            lines_cnt = 0;
            left_dist = dp1;
            restart_pending = 0;
        end
        if (it.mode) restart_pending = 1;
        if (col_now >= w) col_now = 0;
        if (slot_now > dmax) slot_now = 0;
        if (col_now == 0) begin
            slot_now = (slot_now >= dmax) ? 0 : slot_now + 1;
            left_dist = dp1;
            if (lines_cnt < 63) lines_cnt++;
        end
        cur = slot_now;
        prev = (cur == 0) ? dmax : cur - 1;
        idx = cidx(cur, col_now);
        if (lines_cnt > dp1) begin
            p = pix_ring[idx];
            d = dist_ring[idx];
            if (p == 0) begin
                if (d < dp1) p = cfg_grown_one ? 1 : d;
            end else if (cfg_edges_one) begin
                p = 1;
            end
            o.pixel = p[PIX_W-1:0];
            o.eol = (col_now + 1 == w);
            expected_pixels.push_back(o);
        end
        if (!it.mode) begin
            pix_ring[idx] = 16'(it.pixel);
            if (it.pixel == 0) begin
                m = dist_ring[cidx(prev, col_now)];
                if (left_dist < m) m = left_dist;
                m = m + 1;
                nd = (m < dp1) ? m : dp1;
            end else begin
                nd = cfg_edge_val ? int'(it.pixel) : 0;
                if (dist_ring[cidx(prev, col_now)] > nd + 1)
                    flood_fill(prev, col_now, nd + 1, 1, cur, dmax, w);
                if (left_dist > nd + 1 && col_now > 0)
                    flood_fill(cur, col_now - 1, nd + 1, 0, cur, dmax, w);
            end
            dist_ring[idx] = 16'(nd);
            left_dist = nd;
        end
        col_now = col_now + 1;
        if (col_now >= w) col_now = 0;
    endfunction

    // sender
    always @(posedge aclk) begin
        pix_item_t nxt;
        int gap;
        if (s_valid && s_ready)
            predict_pixel('{s_mode, s_pixel_value});
        if (!s_valid || s_ready) begin
            gap = (idle_mode == 0) ? 8 : (idle_mode == 1 ? 86 : 0);
            if (aresetn && pending_pixels.size() > 0 && $urandom_range(0, 99) >= gap) begin
                nxt = pending_pixels.pop_front();
                s_valid <= 1'b1;
                s_mode <= nxt.mode;
                s_pixel_value <= nxt.pixel;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        out_pix_t e;
        int stall;
        if (m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected item pixel_out=%0d end_of_line=%0d",
                         $time, m_pixel_out, m_end_of_line);
            end else begin
                e = expected_pixels.pop_front();
                if (m_pixel_out !== e.pixel) begin
                    errors++;
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, e.pixel, m_pixel_out);
                end
                if (m_end_of_line !== e.eol) begin
                    errors++;
                    $display("%0t: end_of_line expected %0d actual %0d",
                             $time, e.eol, m_end_of_line);
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = 3000;
        end
        stall = (idle_mode == 0) ? 86 : (idle_mode == 1 ? 8 : 0);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= stall);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_city_block_distance_transform test failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, int val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx * 4);
        pwdata <= APB_DW'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_DISTANCE:    cfg_max_dist = val & 'h1f;
            REG_LINE_WIDTH:      cfg_width = val & 'h7ff;
            REG_EDGE_FROM_VALUE: cfg_edge_val = val & 1;
            REG_MARK_EDGES_ONE:  cfg_edges_one = val & 1;
            REG_MARK_GROWN_ONE:  cfg_grown_one = val & 1;
            default: ;
        endcase
    endtask

    task automatic set_config(int dmax, int w, bit ev, bit eo, bit go);
        reg_write(REG_MAX_DISTANCE, dmax);
        reg_write(REG_LINE_WIDTH, w);
        reg_write(REG_EDGE_FROM_VALUE, ev);
        reg_write(REG_MARK_EDGES_ONE, eo);
        reg_write(REG_MARK_GROWN_ONE, go);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return '0;
        if (r < 90) return PIX_W'($urandom_range(1, 40));
        return PIX_W'($urandom_range(1, 32767));
    endfunction

    function automatic void add_image(int n_pix, int n_flush, int noise_pct);
        for (int k = 0; k < n_pix; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                pending_pixels.push_back('{1'b1, PIX_W'($urandom)});
            else
                pending_pixels.push_back('{1'b0, rand_pixel()});
        end
        for (int k = 0; k < n_flush; k++)
            pending_pixels.push_back('{1'b1, PIX_W'($urandom)});
    endfunction

    initial begin
        int dm, w;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: small ring, edges at the field extremes
        set_config(2, 4, 0, 0, 0);
        for (int k = 0; k < 20; k++)
            pending_pixels.push_back('{1'b0, (k == 5) ? 15'h7fff : (k == 10 ? 15'd1 :
                                      (k == 17 ? 15'h5555 : 15'd0))});
        for (int k = 0; k < 12; k++) pending_pixels.push_back('{1'b1, 15'h2aaa});
        wait_drained();

        // saturated registers, unknown register, all output modes
        set_config(0, 0, 1, 1, 1);
        reg_write(3'd7, 'hffff_ffff);
        add_image(10, 3, 0);
        wait_drained();

        // deepest ring, then shrink it mid image so slot and column wrap
        set_config(31, 3, 1, 0, 1);
        add_image(120, 0, 0);
        wait_drained();
        set_config(5, 2, 0, 1, 0);
        add_image(30, 12, 0);
        wait_drained();

        // widest line
        idle_mode = 2;
        set_config(1, 2047, 0, 0, 1);
        add_image(100, 4, 0);
        wait_drained();

        // random images under each idle pattern
        for (int ph = 0; ph < 3; ph++) begin
            idle_mode = ph;
            dm = $urandom_range(1, 6);
            w = $urandom_range(1, 12);
            set_config(dm, w, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1));
            if (ph == 0) hold_req++;
            add_image(60, (dm + 1) * w, 2);
            wait_drained();
        end

        while (expected_pixels.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("bounded_city_block_distance_transform test passed");
        else
            $display("bounded_city_block_distance_transform test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bcdt_pkg.sv
rtl/core/bcdt_ram.sv
rtl/core/bcdt_regs.sv
rtl/core/bounded_city_block_distance_transform.sv
tb/bounded_city_block_distance_transform_tb.sv
